// File: design/bcdca_pkg.sv
// ----------------------------------------------------------------------------
// bcdca_pkg: shared types for the BCD clock with alarm
// Request codes, the digit store type and the command word that runs from
// the front end through the command queue to the execution back end.
// ----------------------------------------------------------------------------
package bcdca_pkg;

  // Request codes as they arrive on req_type; 6 and 7 mean nothing
  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_MIN_UP     = 3'd1,
    OP_HOUR_UP    = 3'd2,
    OP_ENTRY      = 3'd3,
    OP_SHOW_TIME  = 3'd4,
    OP_SHOW_ALARM = 3'd5
  } op_t;

  // Index 0 sec units, 1 sec tens, 2 min units, 3 min tens, 4 hour units, 5 hour tens
  typedef logic [5:0][3:0] digits_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] digit;
    logic       target;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

// File: design/bcdca_front.sv
// ----------------------------------------------------------------------------
// bcdca_front: request intake
// Accepts request words, drops undefined request codes and turns the rest
// into queue commands.
// ----------------------------------------------------------------------------
module bcdca_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_req_type,
  input  logic [3:0]        in_digit,
  input  logic              in_set_target,
  input  logic              q_full,
  output logic              push,
  output bcdca_pkg::cmd_t   wr_cmd
);
  import bcdca_pkg::*;

  logic known;

  always_comb begin
    case (in_req_type) inside
      [OP_TICK:OP_SHOW_ALARM]: known = 1'b1;
      default:                 known = 1'b0;
    endcase
  end

  assign in_stall      = q_full;
  // drop undefined requests: accepted but never queued
  assign push          = in_valid && !q_full && known;
  assign wr_cmd.op     = op_t'(in_req_type);
  assign wr_cmd.digit  = in_digit;
  assign wr_cmd.target = in_set_target;

endmodule

// File: design/bcdca_queue.sv
// ----------------------------------------------------------------------------
// bcdca_queue: command queue
// Small first-in first-out buffer that decouples request intake from
// execution.
// ----------------------------------------------------------------------------
module bcdca_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bcdca_pkg::cmd_t    wr_cmd,
  output logic               full,
  input  logic               pop,
  output bcdca_pkg::q_head_t head
);
  import bcdca_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

// File: design/bcdca_back.sv
// ----------------------------------------------------------------------------
// bcdca_back: command execution
// Holds the time, alarm and entry position, runs one queued command at a
// time and drives the result register; a show runs as eight words.
// ----------------------------------------------------------------------------
module bcdca_back (
  input  logic               clk,
  input  logic               rst_n,
  input  bcdca_pkg::q_head_t head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [11:0]        out_spi_word,
  output logic               out_last,
  output logic               out_alarm_hit,
  output logic               out_entry_done
);
  import bcdca_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SHOW = 2'b10
  } state_t;

  localparam logic [2:0]  POS_HOUR_T = 3'd7;
  localparam logic [2:0]  POS_HOUR_U = 3'd6;
  localparam logic [2:0]  POS_MIN_T  = 3'd4;
  localparam logic [2:0]  POS_MIN_U  = 3'd3;
  localparam logic [2:0]  POS_SEC_T  = 3'd1;
  localparam logic [2:0]  POS_SEC_U  = 3'd0;
  localparam logic [2:0]  WORD_LAST  = 3'd7;
  localparam logic [3:0]  REG_SEC_U  = 4'h1;
  localparam logic [3:0]  REG_SEC_T  = 4'h2;
  localparam logic [3:0]  REG_MIN_U  = 4'h4;
  localparam logic [3:0]  REG_MIN_T  = 4'h5;
  localparam logic [3:0]  REG_HOUR_U = 4'h7;
  localparam logic [3:0]  REG_HOUR_T = 4'h8;
  localparam logic [11:0] SEP_WORD_A = 12'h30A;
  localparam logic [11:0] SEP_WORD_B = 12'h60A;
  localparam logic [11:0] STATUS_WORD = 12'h000;

  function automatic digits_t hour_wrap(digits_t d);
    digits_t r;
    r = d;
    if (r[5] >= 4'd2 && r[4] >= 4'd4) begin
      r[5] = 4'd0;
      r[4] = 4'd0;
    end
    return r;
  endfunction

  // seconds advance with carries; each limit check runs whether or not a carry came in
  function automatic digits_t tick_next(digits_t d);
    logic [4:0] v0, v1, v2, v3, v4, v5;
    digits_t    r;
    v0 = {1'b0, d[0]} + 5'd1;
    v1 = {1'b0, d[1]};
    v2 = {1'b0, d[2]};
    v3 = {1'b0, d[3]};
    v4 = {1'b0, d[4]};
    v5 = {1'b0, d[5]};
    if (v0 > 5'd9) begin v0 = '0; v1 = v1 + 5'd1; end
    if (v1 >= 5'd6) begin v1 = '0; v2 = v2 + 5'd1; end
    if (v2 > 5'd9) begin v2 = '0; v3 = v3 + 5'd1; end
    if (v3 >= 5'd6) begin v3 = '0; v4 = v4 + 5'd1; end
    if (v4 > 5'd9) begin v4 = '0; v5 = v5 + 5'd1; end
    r[0] = v0[3:0];
    r[1] = v1[3:0];
    r[2] = v2[3:0];
    r[3] = v3[3:0];
    r[4] = v4[3:0];
    r[5] = v5[3:0];
    return hour_wrap(r);
  endfunction

  function automatic digits_t min_up_next(digits_t d);
    logic [4:0] u, t;
    digits_t    r;
    r = d;
    u = {1'b0, d[2]} + 5'd1;
    t = {1'b0, d[3]};
    if (u > 5'd9) begin u = '0; t = t + 5'd1; end
    if (t > 5'd5) begin t = '0; end
    r[2] = u[3:0];
    r[3] = t[3:0];
    return r;
  endfunction

  function automatic digits_t hour_up_next(digits_t d);
    logic [4:0] u;
    logic [3:0] t;
    digits_t    r;
    r = d;
    u = {1'b0, d[4]} + 5'd1;
    t = d[5];
    if (u > 5'd9) begin u = '0; t = t + 4'd1; end
    r[4] = u[3:0];
    r[5] = t;
    return hour_wrap(r);
  endfunction

  function automatic logic [11:0] show_word(logic [2:0] idx, digits_t d);
    logic [11:0] w;
    case (idx)
      3'd0:    w = {REG_HOUR_U, 4'h0, d[4]};
      3'd1:    w = {REG_HOUR_T, 4'h0, d[5]};
      3'd2:    w = {REG_MIN_U,  4'h0, d[2]};
      3'd3:    w = {REG_MIN_T,  4'h0, d[3]};
      3'd4:    w = {REG_SEC_U,  4'h0, d[0]};
      3'd5:    w = {REG_SEC_T,  4'h0, d[1]};
      3'd6:    w = SEP_WORD_A;
      default: w = SEP_WORD_B;
    endcase
    return w;
  endfunction

  state_t      state_r, state_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        show_alarm_r, show_alarm_nxt;
  digits_t     time_r, time_nxt;
  digits_t     alarm_r, alarm_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [11:0] word_r, word_nxt;
  logic        last_r, last_nxt;
  logic        hit_r, hit_nxt;
  logic        done_r, done_nxt;

  logic        adv;
  digits_t     tick_d;
  digits_t     entry_d;
  logic        entry_done;

  assign adv    = !out_valid_r || !out_stall;
  assign pop    = adv && (state_r == ST_IDLE) && head.valid;
  assign tick_d = tick_next(time_r);

  always_comb begin
    entry_d    = head.cmd.target ? alarm_r : time_r;
    entry_done = 1'b0;
    case (pos_r)
      POS_HOUR_T: entry_d[5] = head.cmd.digit;
      POS_HOUR_U: entry_d[4] = head.cmd.digit;
      POS_MIN_T:  entry_d[3] = head.cmd.digit;
      POS_MIN_U:  entry_d[2] = head.cmd.digit;
      POS_SEC_T:  entry_d[1] = head.cmd.digit;
      POS_SEC_U: begin
        entry_d[0] = head.cmd.digit;
        entry_done = 1'b1;
      end
      default: ;  // separator position: digit ignored
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    show_alarm_nxt = show_alarm_r;
    time_nxt       = time_r;
    alarm_nxt      = alarm_r;
    pos_nxt        = pos_r;
    out_valid_nxt  = out_valid_r;
    word_nxt       = word_r;
    last_nxt       = last_r;
    hit_nxt        = hit_r;
    done_nxt       = done_r;
    if (adv) begin
      out_valid_nxt = 1'b0;
      if (state_r == ST_SHOW) begin
        out_valid_nxt = 1'b1;
        word_nxt      = show_word(cnt_r, show_alarm_r ? alarm_r : time_r);
        last_nxt      = (cnt_r == WORD_LAST);
        hit_nxt       = 1'b0;
        done_nxt      = 1'b0;
        cnt_nxt       = cnt_r + 3'd1;
        if (cnt_r == WORD_LAST) begin
          state_nxt = ST_IDLE;
        end
      end else if (pop) begin
        out_valid_nxt = 1'b1;
        word_nxt      = STATUS_WORD;
        last_nxt      = 1'b1;
        hit_nxt       = 1'b0;
        done_nxt      = 1'b0;
        case (head.cmd.op)
          OP_TICK: begin
            time_nxt = tick_d;
            hit_nxt  = (tick_d == alarm_r);
          end
          OP_MIN_UP:  time_nxt = min_up_next(time_r);
          OP_HOUR_UP: time_nxt = hour_up_next(time_r);
          OP_ENTRY: begin
            if (head.cmd.target) begin
              alarm_nxt = entry_d;
            end else begin
              time_nxt = entry_d;
            end
            done_nxt = entry_done;
            pos_nxt  = pos_r - 3'd1;
          end
          OP_SHOW_TIME, OP_SHOW_ALARM: begin
            // first word now, the other seven from the show state
            show_alarm_nxt = (head.cmd.op == OP_SHOW_ALARM);
            word_nxt       = show_word(3'd0, (head.cmd.op == OP_SHOW_ALARM) ? alarm_r : time_r);
            last_nxt       = 1'b0;
            cnt_nxt        = 3'd1;
            state_nxt      = ST_SHOW;
          end
          default: out_valid_nxt = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      time_r      <= '0;
      alarm_r     <= '0;
      pos_r       <= POS_HOUR_T;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      time_r      <= time_nxt;
      alarm_r     <= alarm_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    show_alarm_r <= show_alarm_nxt;
    word_r       <= word_nxt;
    last_r       <= last_nxt;
    hit_r        <= hit_nxt;
    done_r       <= done_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_spi_word   = word_r;
  assign out_last       = last_r;
  assign out_alarm_hit  = hit_r;
  assign out_entry_done = done_r;

endmodule

// File: design/bcd_clock_alarm_display.sv
// ----------------------------------------------------------------------------
// bcd_clock_alarm_display: 24-hour BCD clock with alarm and display words
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   request | in_valid in_stall in_req_type in_digit  | in
//           | in_set_target                           |
//   result  | out_valid out_stall out_spi_word        | out
//           | out_last out_alarm_hit out_entry_done   |
//
// Tick, minute-up, hour-up and digit entry each give one status word from
// the back end; a show gives eight display words.
// The back end runs one command at a time; the command queue keeps taking
// requests while it works, until QUEUE_DEPTH commands wait.
// Synchronous reset clears time and alarm to 00:00:00 and the entry position
// to hour tens; out_stall holds the result register and then the back end.
// ----------------------------------------------------------------------------
module bcd_clock_alarm_display #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [3:0]  in_digit,
  input  logic        in_set_target,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_spi_word,
  output logic        out_last,
  output logic        out_alarm_hit,
  output logic        out_entry_done
);
  import bcdca_pkg::*;

  logic    q_full;
  logic    push;
  logic    pop;
  cmd_t    wr_cmd;
  q_head_t head;

  bcdca_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_digit      (in_digit),
    .in_set_target (in_set_target),
    .q_full        (q_full),
    .push          (push),
    .wr_cmd        (wr_cmd)
  );

  bcdca_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_cmd (wr_cmd),
    .full   (q_full),
    .pop    (pop),
    .head   (head)
  );

  bcdca_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_spi_word   (out_spi_word),
    .out_last       (out_last),
    .out_alarm_hit  (out_alarm_hit),
    .out_entry_done (out_entry_done)
  );

endmodule

// File: design/bcdca_checker.sv
// ----------------------------------------------------------------------------
// bcdca_checker: port checks for the BCD clock
// Watches the result channel of the top level; bound in below.
// ----------------------------------------------------------------------------
module bcdca_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [11:0] out_spi_word,
  input logic        out_last,
  input logic        out_alarm_hit,
  input logic        out_entry_done
);

  // an alarm flag only rides on a tick's status word
  a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_alarm_hit |-> out_last && out_spi_word == 12'h000 && !out_entry_done)
    else $error("alarm flag outside a status word");

  a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_done |-> out_last && out_spi_word == 12'h000)
    else $error("entry flag outside a status word");

  // display words always carry a nonzero register number
  a_show_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_spi_word[11:8] != 4'h0)
    else $error("display word without register number");

  // a show burst carries on in the next cycle once a word is taken
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last && !out_stall |=> out_valid)
    else $error("gap inside a show burst");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_spi_word) && $stable(out_last))
    else $error("stalled result word changed");

endmodule

bind bcd_clock_alarm_display bcdca_checker u_chk (.*);

// File: tb/bcd_clock_alarm_display_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_clock_alarm_display_checker: result predictor and scoreboard
// Watches the request and result channels of the BCD clock, keeps its own
// copy of time, alarm and entry position, and checks every result word
// field by field against the oldest word still due.
// ----------------------------------------------------------------------------
module bcd_clock_alarm_display_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [3:0]  in_digit,
  input  logic        in_set_target,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [11:0] out_spi_word,
  input  logic        out_last,
  input  logic        out_alarm_hit,
  input  logic        out_entry_done,
  output int          fail_count,
  output int          pending
);
  import bcdca_pkg::*;

  // Digit store indexes
  localparam int SEC_U = 0;
  localparam int SEC_T = 1;
  localparam int MIN_U = 2;
  localparam int MIN_T = 3;
  localparam int HR_U  = 4;
  localparam int HR_T  = 5;

  // Entry positions; 5 and 2 are separators
  localparam logic [2:0] POS_HR_T  = 3'd7;
  localparam logic [2:0] POS_HR_U  = 3'd6;
  localparam logic [2:0] POS_MIN_T = 3'd4;
  localparam logic [2:0] POS_MIN_U = 3'd3;
  localparam logic [2:0] POS_SEC_T = 3'd1;
  localparam logic [2:0] POS_SEC_U = 3'd0;

  // Display register numbers and separator words
  localparam logic [3:0]  REG_SEC_U = 4'h1;
  localparam logic [3:0]  REG_SEC_T = 4'h2;
  localparam logic [3:0]  REG_MIN_U = 4'h4;
  localparam logic [3:0]  REG_MIN_T = 4'h5;
  localparam logic [3:0]  REG_HR_U  = 4'h7;
  localparam logic [3:0]  REG_HR_T  = 4'h8;
  localparam logic [11:0] SEP_A     = 12'h30A;
  localparam logic [11:0] SEP_B     = 12'h60A;

  typedef struct packed {
    logic [11:0] spi_word;
    logic        last;
    logic        alarm_hit;
    logic        entry_done;
  } disp_word_t;

  digits_t    clock_now;
  digits_t    alarm_set;
  logic [2:0] entry_pos;
  disp_word_t words_due[$];

  function automatic digits_t wrap_hours(digits_t d);
    if (d[HR_T] >= 4'd2 && d[HR_U] >= 4'd4) begin
      d[HR_T] = 4'd0;
      d[HR_U] = 4'd0;
    end
    return d;
  endfunction

  function automatic digits_t tick_second(digits_t d);
    int v [6];
    digits_t r;
    for (int i = 0; i < 6; i++) v[i] = d[i];
    v[SEC_U]++;
    if (v[SEC_U] > 9) begin
      v[SEC_U] = 0;
      v[SEC_T]++;
    end
    if (v[SEC_T] >= 6) begin
      v[SEC_T] = 0;
      v[MIN_U]++;
    end
    if (v[MIN_U] > 9) begin
      v[MIN_U] = 0;
      v[MIN_T]++;
    end
    if (v[MIN_T] >= 6) begin
      v[MIN_T] = 0;
      v[HR_U]++;
    end
    if (v[HR_U] > 9) begin
      v[HR_U] = 0;
      v[HR_T]++;
    end
    for (int i = 0; i < 6; i++) r[i] = 4'(v[i]);
    return wrap_hours(r);
  endfunction

  // Minutes wrap on their own; the hours never see a carry
  function automatic digits_t step_minute(digits_t d);
    int u;
    int t;
    u = d[MIN_U] + 1;
    t = d[MIN_T];
    if (u > 9) begin
      u = 0;
      t++;
    end
    if (t > 5) t = 0;
    d[MIN_U] = 4'(u);
    d[MIN_T] = 4'(t);
    return d;
  endfunction

  function automatic digits_t step_hour(digits_t d);
    int u;
    int t;
    u = d[HR_U] + 1;
    t = d[HR_T];
    if (u > 9) begin
      u = 0;
      t++;
    end
    d[HR_U] = 4'(u);
    d[HR_T] = 4'(t);
    return wrap_hours(d);
  endfunction

  function automatic void queue_word(logic [11:0] word, logic last);
    disp_word_t w;
    w = '0;
    w.spi_word = word;
    w.last = last;
    words_due.push_back(w);
  endfunction

  function automatic void queue_display(digits_t d);
    queue_word({REG_HR_U, 4'h0, d[HR_U]}, 1'b0);
    queue_word({REG_HR_T, 4'h0, d[HR_T]}, 1'b0);
    queue_word({REG_MIN_U, 4'h0, d[MIN_U]}, 1'b0);
    queue_word({REG_MIN_T, 4'h0, d[MIN_T]}, 1'b0);
    queue_word({REG_SEC_U, 4'h0, d[SEC_U]}, 1'b0);
    queue_word({REG_SEC_T, 4'h0, d[SEC_T]}, 1'b0);
    queue_word(SEP_A, 1'b0);
    queue_word(SEP_B, 1'b1);
  endfunction

  function automatic void predict_request(logic [2:0] rt, logic [3:0] dg, logic tg);
    disp_word_t w;
    digits_t    dst;
    w = '0;
    w.last = 1'b1;
    case (rt)
      OP_TICK: begin
        clock_now = tick_second(clock_now);
        w.alarm_hit = (clock_now == alarm_set);
        words_due.push_back(w);
      end
      OP_MIN_UP: begin
        clock_now = step_minute(clock_now);
        words_due.push_back(w);
      end
      OP_HOUR_UP: begin
        clock_now = step_hour(clock_now);
        words_due.push_back(w);
      end
      OP_ENTRY: begin
        dst = tg ? alarm_set : clock_now;
        case (entry_pos)
          POS_HR_T:  dst[HR_T] = dg;
          POS_HR_U:  dst[HR_U] = dg;
          POS_MIN_T: dst[MIN_T] = dg;
          POS_MIN_U: dst[MIN_U] = dg;
          POS_SEC_T: dst[SEC_T] = dg;
          POS_SEC_U: dst[SEC_U] = dg;
          default: ;
        endcase
        w.entry_done = (entry_pos == POS_SEC_U);
        entry_pos = entry_pos - 3'd1;
        if (tg) alarm_set = dst;
        else clock_now = dst;
        words_due.push_back(w);
      end
      OP_SHOW_TIME:  queue_display(clock_now);
      OP_SHOW_ALARM: queue_display(alarm_set);
      default: ;  // unknown request: drop, nothing comes back
    endcase
  endfunction

  always @(posedge clk) begin : watch_channels
    disp_word_t want;
    if (!rst_n) begin
      clock_now = '0;
      alarm_set = '0;
      entry_pos = POS_HR_T;
      words_due.delete();
    end else begin
      // requests first: a result taken on the same edge belongs to an older one
      if (in_valid && !in_stall) predict_request(in_req_type, in_digit, in_set_target);
      if (out_valid && !out_stall) begin
        if (words_due.size() == 0) begin
          $error("unexpected result word: spi_word %03h", out_spi_word);
          fail_count++;
        end else begin
          want = words_due.pop_front();
          if (out_spi_word !== want.spi_word) begin
            $error("spi_word: expected %03h, got %03h", want.spi_word, out_spi_word);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_last);
            fail_count++;
          end
          if (out_alarm_hit !== want.alarm_hit) begin
            $error("alarm_hit: expected %0b, got %0b", want.alarm_hit, out_alarm_hit);
            fail_count++;
          end
          if (out_entry_done !== want.entry_done) begin
            $error("entry_done: expected %0b, got %0b", want.entry_done, out_entry_done);
            fail_count++;
          end
        end
      end
    end
    pending = words_due.size();
  end

endmodule

// File: tb/tb_bcd_clock_alarm_display.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bcd_clock_alarm_display: stimulus and verdict for the BCD clock
// Sends a short directed run (displays, full entries of time and alarm,
// an alarm hit, midnight roll-over, adjustments, unknown requests), then
// random requests with random gaps and result stalls; the checker beside
// the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_bcd_clock_alarm_display;
  import bcdca_pkg::*;

  localparam int CLK_HALF_NS  = 6;
  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_ITEMS = 128;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 200000;

  // Request codes the block ignores
  localparam logic [2:0] REQ_UNUSED_A = 3'd6;
  localparam logic [2:0] REQ_UNUSED_B = 3'd7;
  localparam logic [2:0] ENTRY_START  = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_req_type;
  logic [3:0]  in_digit;
  logic        in_set_target;
  logic        out_valid;
  logic        out_stall;
  logic [11:0] out_spi_word;
  logic        out_last;
  logic        out_alarm_hit;
  logic        out_entry_done;

  int         fail_count;
  int         pending;
  int         cycle_count;
  int         items_sent;
  bit         idle_on;
  logic [2:0] entry_next;

  bcd_clock_alarm_display u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_digit       (in_digit),
    .in_set_target  (in_set_target),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_spi_word   (out_spi_word),
    .out_last       (out_last),
    .out_alarm_hit  (out_alarm_hit),
    .out_entry_done (out_entry_done)
  );

  bcd_clock_alarm_display_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_digit       (in_digit),
    .in_set_target  (in_set_target),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_spi_word   (out_spi_word),
    .out_last       (out_last),
    .out_alarm_hit  (out_alarm_hit),
    .out_entry_done (out_entry_done),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF_NS clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_bcd_clock_alarm_display: FAIL");
      $finish;
    end
  end

  // Hand one request word over; stall is sampled mid-cycle, where it is settled
  task automatic send_req(input logic [2:0] rt, input logic [3:0] dg, input logic tg);
    int gap;
    bit took;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= rt;
    in_digit      <= dg;
    in_set_target <= tg;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    if (rt == OP_ENTRY) entry_next = entry_next - 3'd1;
    if (rt <= OP_SHOW_ALARM) items_sent++;
  endtask

  // Hold the request side until every word due has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Full H,H,sep,M,M,sep,S,S entry; realign first if an earlier entry broke off
  task automatic enter_time(input logic tg, input digits_t d);
    logic [3:0] seq [8];
    seq = '{d[5], d[4], 4'($urandom_range(0, 15)), d[3], d[2],
            4'($urandom_range(0, 15)), d[1], d[0]};
    while (entry_next != ENTRY_START) send_req(OP_ENTRY, 4'($urandom_range(0, 15)), tg);
    for (int i = 0; i < 8; i++) send_req(OP_ENTRY, seq[i], tg);
  endtask

  function automatic digits_t random_time(bit raw);
    logic [3:0] ht;
    if (raw) return digits_t'($urandom);
    ht = 4'($urandom_range(0, 2));
    return {ht, 4'($urandom_range(0, (ht == 4'd2) ? 3 : 9)),
            4'($urandom_range(0, 5)), 4'($urandom_range(0, 9)),
            4'($urandom_range(0, 5)), 4'($urandom_range(0, 9))};
  endfunction

  task automatic send_ticks(input int n);
    repeat (n) send_req(OP_TICK, 4'($urandom_range(0, 15)), 1'($urandom));
  endtask

  // Result side: before each word, stall at random while idle_on is set
  initial begin : result_side
    int hold;
    bit took;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      hold = idle_on ? $urandom_range(0, 3) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do begin
        @(negedge clk);
        took = out_valid;
        @(posedge clk);
      end while (!took);
    end
  end

  initial begin : request_side
    int target_count;
    int pick;
    int round;
    int k;
    digits_t a;
    digits_t t;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_req_type   <= OP_TICK;
    in_digit      <= 4'd0;
    in_set_target <= 1'b0;
    idle_on    = 1'b1;
    entry_next = ENTRY_START;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    send_req(OP_SHOW_TIME, 4'h0, 1'b0);
    send_req(OP_SHOW_ALARM, 4'hF, 1'b1);
    enter_time(1'b1, {4'd2, 4'd3, 4'd5, 4'd9, 4'd5, 4'd9});
    enter_time(1'b0, {4'd2, 4'd3, 4'd5, 4'd9, 4'd5, 4'd8});
    send_ticks(2);  // first meets the alarm, second rolls over midnight
    send_req(OP_MIN_UP, 4'h0, 1'b0);
    send_req(OP_HOUR_UP, 4'hF, 1'b1);
    send_req(REQ_UNUSED_A, 4'hF, 1'b1);
    send_req(REQ_UNUSED_B, 4'h0, 1'b0);
    send_req(OP_SHOW_TIME, 4'h0, 1'b0);
    wait_drained();

    target_count = items_sent + RANDOM_ITEMS;
    round = 0;
    while (items_sent < target_count) begin
      round++;
      if (round % 25 == 0) begin
        wait_drained();
        idle_on = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
        enter_time(1'($urandom), random_time($urandom_range(0, 7) == 0));
      end else if (pick < 22) begin
        // set the time a few seconds short of the alarm, then tick through it
        a = random_time(1'b0);
        k = $urandom_range(0, (a[0] > 4'd4) ? 4 : int'(a[0]));
        t = a;
        t[0] = a[0] - 4'(k);
        enter_time(1'b1, a);
        enter_time(1'b0, t);
        send_ticks(k + 1);
      end else if (pick < 26) begin
        enter_time(1'b0, {4'd2, 4'd3, 4'd5, 4'd9, 4'd5, 4'($urandom_range(5, 9))});
        send_ticks($urandom_range(1, 6));
      end else if (pick < 48) begin
        send_ticks(1);
      end else if (pick < 56) begin
        send_req(OP_MIN_UP, 4'($urandom_range(0, 15)), 1'($urandom));
      end else if (pick < 62) begin
        send_req(OP_HOUR_UP, 4'($urandom_range(0, 15)), 1'($urandom));
      end else if (pick < 70) begin
        send_req(OP_ENTRY, 4'($urandom_range(0, 15)), 1'($urandom));
      end else if (pick < 78) begin
        send_req(OP_SHOW_TIME, 4'($urandom_range(0, 15)), 1'($urandom));
      end else if (pick < 84) begin
        send_req(OP_SHOW_ALARM, 4'($urandom_range(0, 15)), 1'($urandom));
      end else if (pick < 88) begin
        send_req($urandom_range(0, 1) ? REQ_UNUSED_A : REQ_UNUSED_B,
                 4'($urandom_range(0, 15)), 1'($urandom));
      end else begin
        send_ticks($urandom_range(2, 12));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_bcd_clock_alarm_display: PASS");
    end else begin
      $display("tb_bcd_clock_alarm_display: FAIL");
    end
    $finish;
  end

endmodule
